// ===== rtl/ttcm_pkg.sv =====
// ----------------------------------------------------------------------------
// ttcm_pkg
// Shared constants, types and arithmetic helpers of the texture coordinate
// mapper: fixed-point widths, register indexes, tile modes and stage records.
// ----------------------------------------------------------------------------
`default_nettype none

package ttcm_pkg;

    localparam int COORD_BITS = 12;
    localparam int FRAC_BITS  = 16;

    localparam int COEF_W  = 32;
    localparam int PIX2_W  = COORD_BITS + 2;          // signed 2*p+1
    localparam int PROD_W  = COEF_W + PIX2_W;
    localparam int SUM_W   = PROD_W + 2;
    localparam int T_W     = 32 - FRAC_BITS;          // signed texel index
    localparam int D_W     = T_W - 1;                 // magnitude for reduction
    localparam int SIZE_W  = COORD_BITS + 1;
    localparam int MOD_W   = COORD_BITS + 2;
    localparam int RW      = D_W + MOD_W;
    localparam int CW      = ((D_W > SIZE_W) ? D_W : SIZE_W) + 1;
    localparam int SPS     = 4;                       // reduction steps per stage
    localparam int RED_ST  = (D_W + SPS - 1) / SPS;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SCALE_X = 3'd0,
        REG_SKEW_X  = 3'd1,
        REG_TRANS_X = 3'd2,
        REG_SKEW_Y  = 3'd3,
        REG_SCALE_Y = 3'd4,
        REG_TRANS_Y = 3'd5,
        REG_MODE    = 3'd6,
        REG_DIMS    = 3'd7
    } reg_idx_t;

    localparam logic [1:0] MODE_CLAMP  = 2'd0;
    localparam logic [1:0] MODE_REPEAT = 2'd1;
    localparam logic [1:0] MODE_MIRROR = 2'd2;

    typedef struct packed {
        logic signed [COEF_W-1:0] scale_x;
        logic signed [COEF_W-1:0] skew_x;
        logic signed [COEF_W-1:0] trans_x;
        logic signed [COEF_W-1:0] skew_y;
        logic signed [COEF_W-1:0] scale_y;
        logic signed [COEF_W-1:0] trans_y;
    } matrix_t;

    typedef struct packed {
        logic signed [T_W-1:0] tx;
        logic signed [T_W-1:0] ty;
        logic                  span;
    } coord_t;

    typedef struct packed {
        logic signed [T_W-1:0] t;
        logic                  neg;
        logic [D_W-1:0]        r;
        logic [MOD_W-1:0]      m;
        logic [SIZE_W-1:0]     size;
    } axis_t;

    typedef struct packed {
        axis_t x;
        axis_t y;
        logic  span;
    } bst_t;

    // Saturate a doubled mapped value to the Q range and floor it to a texel index
    function automatic logic signed [T_W-1:0] sat_floor(logic signed [SUM_W-1:0] s);
        logic [SUM_W-33:0] top;
        logic signed [T_W-1:0] t;
        top = s[SUM_W-1:32];
        if ((&top) || !(|top))
            t = s[32:FRAC_BITS+1];
        else if (s[SUM_W-1])
            t = {1'b1, {(T_W-1){1'b0}}};
        else
            t = {1'b0, {(T_W-1){1'b1}}};
        return t;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/ttcm_if.sv =====
// ----------------------------------------------------------------------------
// ttcm interfaces
// Valid/ready channels for pixels in, texels out and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface ttcm_pix_if import ttcm_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic                  span_end;
    modport source (output valid, pixel_x, pixel_y, span_end, input ready);
    modport sink   (input valid, pixel_x, pixel_y, span_end, output ready);
endinterface

interface ttcm_tex_if import ttcm_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] texel_x;
    logic [COORD_BITS-1:0] texel_y;
    logic                  span_last;
    modport source (output valid, texel_x, texel_y, span_last, input ready);
    modport sink   (input valid, texel_x, texel_y, span_last, output ready);
endinterface

interface ttcm_cfg_if import ttcm_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/texture_tile_coordinate_mapper.sv =====
// ----------------------------------------------------------------------------
// texture_tile_coordinate_mapper
// Pipeline: 9 register stages from pixel transfer to texel valid (2 front,
// 1 queue entry, prep, 4 modulo, output). Throughput: one pixel per cycle
// unless the texel side stalls; the pipelined modulo unit sets the depth.
// Reset: matrix is identity, clamp mode, 64 x 64 bitmap, all stages empty.
// ----------------------------------------------------------------------------
`default_nettype none

module texture_tile_coordinate_mapper import ttcm_pkg::*; (
    input  wire logic  clk,
    input  wire logic  rst_n,
    ttcm_pix_if.sink   pix,
    ttcm_tex_if.source tex,
    ttcm_cfg_if.sink   cfg
);

    matrix_t                 mat_reg;
    logic [1:0]              mode_reg;
    logic [2*COORD_BITS-1:0] dims_reg;

    logic   q_in_valid, q_in_ready, q_out_valid, q_out_ready;
    coord_t q_in_data, q_out_data;

    assign cfg.ready = 1'b1;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mat_reg.scale_x <= 32'sd65536;
            mat_reg.skew_x  <= '0;
            mat_reg.trans_x <= '0;
            mat_reg.skew_y  <= '0;
            mat_reg.scale_y <= 32'sd65536;
            mat_reg.trans_y <= '0;
            mode_reg        <= MODE_CLAMP;
            dims_reg        <= (2*COORD_BITS)'(258111);
        end
        else if (cfg.valid)
        begin
            case (reg_idx_t'(cfg.index))
                REG_SCALE_X: mat_reg.scale_x <= cfg.data;
                REG_SKEW_X:  mat_reg.skew_x  <= cfg.data;
                REG_TRANS_X: mat_reg.trans_x <= cfg.data;
                REG_SKEW_Y:  mat_reg.skew_y  <= cfg.data;
                REG_SCALE_Y: mat_reg.scale_y <= cfg.data;
                REG_TRANS_Y: mat_reg.trans_y <= cfg.data;
                REG_MODE:    mode_reg        <= cfg.data[1:0];
                REG_DIMS:    dims_reg        <= cfg.data[2*COORD_BITS-1:0];
                default:     mode_reg        <= mode_reg;
            endcase
        end
    end

    ttcm_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .mat        (mat_reg),
        .pix        (pix),
        .push_valid (q_in_valid),
        .push_ready (q_in_ready),
        .push_data  (q_in_data)
    );

    ttcm_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (q_in_valid),
        .in_ready  (q_in_ready),
        .in_data   (q_in_data),
        .out_valid (q_out_valid),
        .out_ready (q_out_ready),
        .out_data  (q_out_data)
    );

    ttcm_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .mode     (mode_reg),
        .dims     (dims_reg),
        .in_valid (q_out_valid),
        .in_ready (q_out_ready),
        .in_data  (q_out_data),
        .tex      (tex)
    );

endmodule

`default_nettype wire

// ===== rtl/ttcm_front.sv =====
// ----------------------------------------------------------------------------
// ttcm_front
// Accept pixels, map the pixel center through the affine matrix and floor
// the saturated result to signed texel indexes. Two pipeline stages.
// ----------------------------------------------------------------------------
`default_nettype none

module ttcm_front import ttcm_pkg::*; (
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire matrix_t mat,
    ttcm_pix_if.sink    pix,
    output logic        push_valid,
    input  wire logic   push_ready,
    output coord_t      push_data
);

    logic                     s1_v_reg;
    logic signed [PROD_W-1:0] pax_reg, pbx_reg, pay_reg, pby_reg;
    logic signed [COEF_W-1:0] cx_reg, cy_reg;
    logic                     span1_reg;
    logic                     s2_v_reg;
    coord_t                   s2_reg;
    logic                     s1_ready, s2_ready;
    logic signed [PIX2_W-1:0] px2, py2;
    logic signed [SUM_W-1:0]  sum_x, sum_y;

    // Advance a stage when it is empty or its contents move on
    assign s2_ready = !s2_v_reg || push_ready;
    assign s1_ready = !s1_v_reg || s2_ready;
    assign pix.ready = s1_ready;

    // Doubled pixel centers
    assign px2 = $signed({1'b0, pix.pixel_x, 1'b1});
    assign py2 = $signed({1'b0, pix.pixel_y, 1'b1});

    // Stage 1: products
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_v_reg <= 1'b0;
        else if (s1_ready)
            s1_v_reg <= pix.valid;
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && pix.valid)
        begin
            pax_reg   <= mat.scale_x * px2;
            pbx_reg   <= mat.skew_x  * py2;
            pay_reg   <= mat.skew_y  * px2;
            pby_reg   <= mat.scale_y * py2;
            cx_reg    <= mat.trans_x;
            cy_reg    <= mat.trans_y;
            span1_reg <= pix.span_end;
        end
    end

    // Stage 2: sum, saturate, floor
    assign sum_x = SUM_W'(pax_reg) + SUM_W'(pbx_reg) + SUM_W'($signed({cx_reg, 1'b0}));
    assign sum_y = SUM_W'(pay_reg) + SUM_W'(pby_reg) + SUM_W'($signed({cy_reg, 1'b0}));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_v_reg <= 1'b0;
        else if (s2_ready)
            s2_v_reg <= s1_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_v_reg)
        begin
            s2_reg.tx   <= sat_floor(sum_x);
            s2_reg.ty   <= sat_floor(sum_y);
            s2_reg.span <= span1_reg;
        end
    end

    assign push_valid = s2_v_reg;
    assign push_data  = s2_reg;

endmodule

`default_nettype wire

// ===== rtl/ttcm_fifo.sv =====
// ----------------------------------------------------------------------------
// ttcm_fifo
// Short queue of mapped coordinates between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module ttcm_fifo import ttcm_pkg::*; (
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   in_valid,
    output logic        in_ready,
    input  wire coord_t in_data,
    output logic        out_valid,
    input  wire logic   out_ready,
    output coord_t      out_data
);

    coord_t               mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_AW:0]     count_reg, count_next;
    logic                 push, pop;

    assign in_ready  = (count_reg != (FIFO_AW+1)'(FIFO_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign push = in_valid && in_ready;
    assign pop  = out_valid && out_ready;

    // Track fill level
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
        end
    end

    // Store entries
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= in_data;
    end

endmodule

`default_nettype wire

// ===== rtl/ttcm_back.sv =====
// ----------------------------------------------------------------------------
// ttcm_back
// Apply the tile mode: a prep stage, a pipelined restoring modulo reduction
// (SPS quotient bits per stage) and a registered select of the final texel.
// ----------------------------------------------------------------------------
`default_nettype none

module ttcm_back import ttcm_pkg::*; (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic [1:0]            mode,
    input  wire logic [2*COORD_BITS-1:0] dims,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire coord_t                in_data,
    ttcm_tex_if.source                 tex
);

    // Prepare one axis: magnitude, sign, size and modulus
    function automatic axis_t prep_axis(logic signed [T_W-1:0] t,
                                        logic [COORD_BITS-1:0] dim,
                                        logic [1:0] md);
        axis_t a;
        a.t    = t;
        a.neg  = t[T_W-1];
        a.r    = t[T_W-1] ? ~t[D_W-1:0] : t[D_W-1:0];
        a.size = {1'b0, dim} + 1'b1;
        a.m    = (md == MODE_MIRROR) ? {a.size, 1'b0} : {1'b0, a.size};
        return a;
    endfunction

    // Run SPS restoring steps of the remainder for stage j
    function automatic axis_t red_axis(axis_t a, int j);
        axis_t o;
        int k;
        logic [D_W-1:0] hi;
        logic [RW-1:0]  sub;
        o = a;
        for (int i = 0; i < SPS; i++)
        begin
            k = D_W - 1 - j * SPS - i;
            if (k >= 0)
            begin
                hi = o.r >> k;
                if (RW'(hi) >= RW'(o.m))
                begin
                    sub = RW'(o.r) - (RW'(o.m) << k);
                    o.r = sub[D_W-1:0];
                end
            end
        end
        return o;
    endfunction

    // Pick the texel for the tile mode
    function automatic logic [COORD_BITS-1:0] tile_axis(axis_t a, logic [1:0] md);
        logic [MOD_W-1:0] rm, res;
        logic [CW-1:0]    tmag, sz;
        rm   = a.neg ? (a.m - 1'b1 - MOD_W'(a.r)) : MOD_W'(a.r);
        tmag = CW'(a.t[D_W-1:0]);
        sz   = CW'(a.size);
        case (md)
            MODE_REPEAT: res = rm;
            MODE_MIRROR: res = (rm < MOD_W'(a.size)) ? rm : (a.m - 1'b1 - rm);
            default:
            begin
                if (a.neg)
                    res = '0;
                else if (tmag >= sz)
                    res = MOD_W'(a.size - 1'b1);
                else
                    res = MOD_W'(tmag);
            end
        endcase
        return res[COORD_BITS-1:0];
    endfunction

    logic                  v_reg [RED_ST+1];
    bst_t                  st_reg [RED_ST+1];
    logic                  rdy [RED_ST+2];
    logic                  out_v_reg;
    logic [COORD_BITS-1:0] out_x_reg, out_y_reg;
    logic                  out_span_reg;

    // Ready chain from the output register back to the queue
    always_comb
    begin
        rdy[RED_ST+1] = !out_v_reg || tex.ready;
        for (int j = RED_ST; j >= 0; j--)
            rdy[j] = !v_reg[j] || rdy[j+1];
    end
    assign in_ready = rdy[0];

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j <= RED_ST; j++)
                v_reg[j] <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (rdy[0])
                v_reg[0] <= in_valid;
            for (int j = 1; j <= RED_ST; j++)
                if (rdy[j])
                    v_reg[j] <= v_reg[j-1];
            if (rdy[RED_ST+1])
                out_v_reg <= v_reg[RED_ST];
        end
    end

    // Advance payloads
    always_ff @(posedge clk)
    begin
        if (rdy[0] && in_valid)
        begin
            st_reg[0].x    <= prep_axis(in_data.tx, dims[COORD_BITS-1:0], mode);
            st_reg[0].y    <= prep_axis(in_data.ty, dims[2*COORD_BITS-1:COORD_BITS], mode);
            st_reg[0].span <= in_data.span;
        end
        for (int j = 1; j <= RED_ST; j++)
        begin
            if (rdy[j] && v_reg[j-1])
            begin
                st_reg[j].x    <= red_axis(st_reg[j-1].x, j - 1);
                st_reg[j].y    <= red_axis(st_reg[j-1].y, j - 1);
                st_reg[j].span <= st_reg[j-1].span;
            end
        end
        if (rdy[RED_ST+1] && v_reg[RED_ST])
        begin
            out_x_reg    <= tile_axis(st_reg[RED_ST].x, mode);
            out_y_reg    <= tile_axis(st_reg[RED_ST].y, mode);
            out_span_reg <= st_reg[RED_ST].span;
        end
    end

    assign tex.valid     = out_v_reg;
    assign tex.texel_x   = out_x_reg;
    assign tex.texel_y   = out_y_reg;
    assign tex.span_last = out_span_reg;

endmodule

`default_nettype wire

// ===== dv/ttcm_tb_if.sv =====
// ----------------------------------------------------------------------------
// ttcm testbench channel notes
// The channel interfaces come from the RTL interface file; this file holds
// the testbench-side record types shared by the top module.
// ----------------------------------------------------------------------------
`default_nettype none

package ttcm_tb_pkg;
    import ttcm_pkg::*;

    typedef struct packed {
        logic [COORD_BITS-1:0] tx;
        logic [COORD_BITS-1:0] ty;
        logic                  last;
    } texel_rec_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] px;
        logic [COORD_BITS-1:0] py;
        logic                  span;
        logic                  known;   // expected texel typed into the table
        logic [COORD_BITS-1:0] kx;
        logic [COORD_BITS-1:0] ky;
    } pixel_row_t;
endpackage

`default_nettype wire

// ===== dv/texture_tile_coordinate_mapper_tb.sv =====
// ----------------------------------------------------------------------------
// texture_tile_coordinate_mapper_tb
// Drives pixels through several matrix, tile mode and bitmap size settings,
// predicts each texel with a 64-bit fixed-point mapper unless the directed
// table gives it, and compares results in order, under random idling on both sides of the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module texture_tile_coordinate_mapper_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ttcm_pkg::*;
    import ttcm_tb_pkg::*;

    localparam int DRAIN_CYCLES = 20;
    localparam int WATCHDOG_LIMIT = 20000;

    logic clk;
    logic rst_n;

    ttcm_pix_if pix ();
    ttcm_tex_if tex ();
    ttcm_cfg_if cfg ();

    texture_tile_coordinate_mapper dut (
        .clk   (clk),
        .rst_n (rst_n),
        .pix   (pix.sink),
        .tex   (tex.source),
        .cfg   (cfg.sink)
    );

    // Shadow copy of the configuration
    logic [31:0] coef [0:5];
    logic [1:0]  wrap_mode;
    logic [23:0] dims;

    texel_rec_t  texel_queue [$];
    int          errors = 0;
    int          idle_cycles = 0;
    int          src_gap_pct;
    int          snk_gap_pct;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Map one axis: exact sum of doubled center, saturate, floor
    function automatic longint map_axis(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                                        longint px2, longint py2);
        longint lim;
        longint s;
        lim = longint'(1) << 32;
        s = longint'($signed(a)) * px2 + longint'($signed(b)) * py2
            + 2 * longint'($signed(c));
        if (s < -lim) s = -lim;
        if (s > lim - 1) s = lim - 1;
        return ((s + lim) >>> (FRAC_BITS + 1)) - (longint'(1) << (31 - FRAC_BITS));
    endfunction

    function automatic longint pos_mod(longint t, longint m);
        longint r;
        r = t % m;
        if (r < 0) r += m;
        return r;
    endfunction

    function automatic logic [COORD_BITS-1:0] wrap_index(longint t, longint size);
        longint r;
        if (wrap_mode == MODE_REPEAT)
            r = pos_mod(t, size);
        else if (wrap_mode == MODE_MIRROR) begin
            r = pos_mod(t, 2 * size);
            if (r >= size) r = 2 * size - 1 - r;
        end
        else if (t < 0) r = 0;
        else if (t > size - 1) r = size - 1;
        else r = t;
        return r[COORD_BITS-1:0];
    endfunction

    function automatic texel_rec_t predict_texel(logic [11:0] px, logic [11:0] py,
                                                 logic span);
        texel_rec_t rec;
        longint px2;
        longint py2;
        px2 = 2 * longint'(px) + 1;
        py2 = 2 * longint'(py) + 1;
        rec.tx = wrap_index(map_axis(coef[0], coef[1], coef[2], px2, py2),
                            longint'(dims[11:0]) + 1);
        rec.ty = wrap_index(map_axis(coef[3], coef[4], coef[5], px2, py2),
                            longint'(dims[23:12]) + 1);
        rec.last = span;
        return rec;
    endfunction

    // Receiver: random stall, compare each texel transfer
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tex.ready <= 1'b0;
        else
            tex.ready <= ($urandom_range(99) >= snk_gap_pct);
    end

    always @(posedge clk)
    begin
        texel_rec_t got;
        texel_rec_t want;
        if (rst_n && tex.valid && tex.ready) begin
            got = '{tex.texel_x, tex.texel_y, tex.span_last};
            if (texel_queue.size() == 0) begin
                $display("%0t: unexpected texel got %h", $time, got);
                errors++;
            end
            else begin
                want = texel_queue.pop_front();
                if (got.tx !== want.tx)
                    $display("%0t: texel_x expected %0d actual %0d", $time, want.tx, got.tx);
                if (got.ty !== want.ty)
                    $display("%0t: texel_y expected %0d actual %0d", $time, want.ty, got.ty);
                if (got.last !== want.last)
                    $display("%0t: span_last expected %0b actual %0b",
                             $time, want.last, got.last);
                if (got !== want) errors++;
            end
        end
    end

    // Watchdog: count cycles with no transfer anywhere
    always @(posedge clk)
    begin
        if ((pix.valid && pix.ready) || (tex.valid && tex.ready) ||
            (cfg.valid && cfg.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("texture_tile_coordinate_mapper_tb: errors");
            $finish;
        end
    end

    // Hold valid into the next write or the next pixel, which drops it
    task automatic write_reg(reg_idx_t idx, logic [31:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        @(posedge clk);
        while (!cfg.ready) @(posedge clk);
        if (idx <= REG_TRANS_Y) coef[idx] = value;
        else if (idx == REG_MODE) wrap_mode = value[1:0];
        else dims = value[23:0];
    endtask

    // Hold until every texel is back, then for a further DRAIN_CYCLES
    task automatic wait_drained();
        pix.valid <= 1'b0;
        while (texel_queue.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic send_pixel(logic [11:0] px, logic [11:0] py, logic span,
                              bit known, logic [11:0] kx, logic [11:0] ky);
        texel_rec_t rec;
        cfg.valid <= 1'b0;
        if ($urandom_range(99) < src_gap_pct) begin
            pix.valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < src_gap_pct) @(posedge clk);
        end
        pix.valid    <= 1'b1;
        pix.pixel_x  <= px;
        pix.pixel_y  <= py;
        pix.span_end <= span;
        rec = predict_texel(px, py, span);
        if (known) begin
            rec.tx = kx;
            rec.ty = ky;
        end
        texel_queue.push_back(rec);
        @(posedge clk);
        while (!pix.ready) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_coef();
        case ($urandom_range(5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom;
            default: return $signed($urandom_range(8 * 65536)) - 4 * 65536;
        endcase
    endfunction

    // Random matrix, mode and size; half of the sizes are small bitmaps
    task automatic random_setting();
        for (int i = 0; i <= 5; i++)
            write_reg(reg_idx_t'(i), rand_coef());
        write_reg(REG_MODE, $urandom_range(3));
        case ($urandom_range(3))
            0: write_reg(REG_DIMS, $urandom);
            1: write_reg(REG_DIMS, 24'hFFFFFF);
            default: write_reg(REG_DIMS, {8'd0, 12'($urandom_range(63)),
                                          12'($urandom_range(63))});
        endcase
    endtask

    pixel_row_t directed_rows [] = '{
        // Reset identity, 64x64 clamp: texel = pixel within the bitmap
        '{12'd0,    12'd0,    1'b0, 1'b1, 12'd0,  12'd0},
        '{12'd63,   12'd63,   1'b1, 1'b1, 12'd63, 12'd63},
        '{12'd64,   12'd5,    1'b0, 1'b1, 12'd63, 12'd5},
        '{12'hFFF,  12'hFFF,  1'b1, 1'b1, 12'd63, 12'd63},
        '{12'hAAA,  12'h555,  1'b0, 1'b0, 12'd0,  12'd0},
        '{12'h555,  12'hAAA,  1'b1, 1'b0, 12'd0,  12'd0}
    };

    initial
    begin
        rst_n = 1'b0;
        src_gap_pct = 0;
        snk_gap_pct = 0;
        pix.valid = 1'b0;
        pix.pixel_x = '0;
        pix.pixel_y = '0;
        pix.span_end = 1'b0;
        cfg.valid = 1'b0;
        cfg.index = REG_SCALE_X;
        cfg.data = '0;
        coef[0] = 32'h0001_0000; coef[1] = 0; coef[2] = 0;
        coef[3] = 0; coef[4] = 32'h0001_0000; coef[5] = 0;
        wrap_mode = MODE_CLAMP;
        dims = 24'd258111;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset setting, then extremes of every mode
        foreach (directed_rows[i])
            send_pixel(directed_rows[i].px, directed_rows[i].py, directed_rows[i].span,
                       directed_rows[i].known, directed_rows[i].kx, directed_rows[i].ky);
        wait_drained();
        for (int m = 0; m < 4; m++) begin
            write_reg(REG_MODE, m);
            write_reg(REG_TRANS_X, 32'hFFF0_0000);      // shift left by 16 texels
            write_reg(REG_DIMS, (m == 3) ? 32'd0 : 32'h0000_7009);
            send_pixel(12'd0, 12'd0, 1'b0, 1'b0, 12'd0, 12'd0);
            send_pixel(12'd3, 12'hFFF, 1'b1, 1'b0, 12'd0, 12'd0);
            wait_drained();
        end
        // Saturation at both ends of the fixed-point range
        write_reg(REG_SCALE_X, 32'h7FFF_FFFF);
        write_reg(REG_SKEW_X, 32'h7FFF_FFFF);
        write_reg(REG_SKEW_Y, 32'h8000_0000);
        write_reg(REG_SCALE_Y, 32'h8000_0000);
        write_reg(REG_TRANS_Y, 32'h8000_0000);
        write_reg(REG_MODE, MODE_CLAMP);
        write_reg(REG_DIMS, 24'hFFFFFF);
        send_pixel(12'hFFF, 12'hFFF, 1'b0, 1'b1, 12'hFFF, 12'd0);
        send_pixel(12'd0, 12'd0, 1'b1, 1'b0, 12'd0, 12'd0);
        wait_drained();
        write_reg(REG_MODE, MODE_MIRROR);
        send_pixel(12'hFFF, 12'h800, 1'b0, 1'b0, 12'd0, 12'd0);
        wait_drained();

        // Random phases: receiver idles most, then sender idles most, then neither
        for (int phase = 0; phase < 3; phase++) begin
            src_gap_pct = (phase == 0) ? 12 : (phase == 1) ? 68 : 0;
            snk_gap_pct = (phase == 0) ? 68 : (phase == 1) ? 12 : 0;
            for (int s = 0; s < 12; s++) begin
                random_setting();
                for (int n = 0; n < 30; n++) begin
                    if (n == 15 && s == 5) wait_drained();
                    send_pixel(12'($urandom), 12'($urandom), 1'($urandom),
                               1'b0, 12'd0, 12'd0);
                end
                wait_drained();
            end
        end

        if (errors == 0)
            $display("texture_tile_coordinate_mapper_tb: clean");
        else
            $display("texture_tile_coordinate_mapper_tb: errors");
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/ttcm_pkg.sv
rtl/ttcm_if.sv
rtl/ttcm_front.sv
rtl/ttcm_fifo.sv
rtl/ttcm_back.sv
rtl/texture_tile_coordinate_mapper.sv
dv/ttcm_tb_if.sv
dv/texture_tile_coordinate_mapper_tb.sv
